[design/hgss_pkg.sv]
// Shared types and constants for the hypergeometric sequential sampler.
// No dependencies; imported by the top level and its port checker.
package hgss_pkg;

  // Default datapath sizing, handed to the top-level parameters.
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 32;

  // Fixed field widths on the stream ports.
  localparam int unsigned MARKED_W   = 16;
  localparam int unsigned UNMARKED_W = 16;
  localparam int unsigned SAMPLE_W   = 17;
  localparam int unsigned UNIFORM_W  = 32;
  localparam int unsigned OUT_W      = 16;

  // Input tdata layout, lowest field first.
  localparam int unsigned MARKED_LSB   = 0;
  localparam int unsigned UNMARKED_LSB = MARKED_LSB + MARKED_W;
  localparam int unsigned SAMPLE_LSB   = UNMARKED_LSB + UNMARKED_W;
  localparam int unsigned UNIFORM_LSB  = SAMPLE_LSB + SAMPLE_W;
  localparam int unsigned IN_FIELDS_W  = UNIFORM_LSB + UNIFORM_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;

  // Command carried on tuser.
  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_DRAW  = 1'b1
  } cmd_e;

endpackage

[design/hypergeometric_sequential_sampler_unit.sv]
// Hypergeometric sampler by sequential selection: one registered pass per item.
// Depends on hgss_pkg (field widths, tdata layout, command codes).
//
//   channel  | dir | tdata (lsb first)                              | tuser
//   ---------+-----+------------------------------------------------+---------------
//   s_axis   | in  | marked_count[16], unmarked_count[16],          | command[1]
//            |     | sample_size[17], uniform_fraction[32], pad[7]  |
//   m_axis   | out | marked_in_sample[16]                           | -
//
// Unless stalled, one item may be taken each cycle. An accepted
// item sits in the input register until the pass can take it; the multiply-compare and
// counter update then run in a single pass into the sampler state and the result
// register, so a result reaches m_axis through the input and result registers.
// rst_ni clears the handshake flags and the sampler state (idle, no sample).
// A result held in the output register stalls the pass whenever an item waits
// in the input register; s_axis_tready drops only then.
module hypergeometric_sequential_sampler_unit #(
  parameter int unsigned CountBits = hgss_pkg::COUNT_BITS_DEF,
  parameter int unsigned FracBits  = hgss_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // marked_count, unmarked_count, sample_size, uniform_fraction, zero pad
  input  logic [hgss_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // command
  input  logic [0:0]                         s_axis_tuser,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // marked_in_sample
  output logic [hgss_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready
);
  import hgss_pkg::*;

  localparam int unsigned PopW   = CountBits + 1;
  localparam int unsigned ProdW  = PopW + FracBits;
  localparam int unsigned ShiftR = (FracBits <= UNIFORM_W) ? UNIFORM_W - FracBits : 0;
  localparam int unsigned ShiftL = (FracBits > UNIFORM_W) ? FracBits - UNIFORM_W : 0;
  localparam int unsigned WideW  = UNIFORM_W + ShiftL;

  // ---------------------------------------------------------------- input stage
  logic                  in_valid_q;
  cmd_e                  in_cmd_q;
  logic [MARKED_W-1:0]   in_marked_q;
  logic [UNMARKED_W-1:0] in_unmarked_q;
  logic [SAMPLE_W-1:0]   in_sample_q;
  logic [UNIFORM_W-1:0]  in_uniform_q;

  logic in_xfer, advance, fire;

  // result register
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_cmd_q      <= cmd_e'(s_axis_tuser);
      in_marked_q   <= s_axis_tdata[MARKED_LSB +: MARKED_W];
      in_unmarked_q <= s_axis_tdata[UNMARKED_LSB +: UNMARKED_W];
      in_sample_q   <= s_axis_tdata[SAMPLE_LSB +: SAMPLE_W];
      in_uniform_q  <= s_axis_tdata[UNIFORM_LSB +: UNIFORM_W];
    end
  end

  // ---------------------------------------------------------------- sampler state
  logic                 busy_q, busy_d;
  logic                 comp_q, comp_d;       // drawing the complement
  logic [CountBits-1:0] mtotal_q, mtotal_d;
  logic [CountBits-1:0] mleft_q, mleft_d;
  logic [PopW-1:0]      pop_q, pop_d;
  logic [CountBits-1:0] found_q, found_d;
  logic [PopW-1:0]      draws_q, draws_d;

  // start decode
  logic [CountBits-1:0] st_m, st_um;
  logic [PopW-1:0]      st_n, st_t, st_tc, st_draws;
  logic                 st_comp;

  assign st_m     = CountBits'(in_marked_q);
  assign st_um    = CountBits'(in_unmarked_q);
  assign st_n     = PopW'(st_m) + PopW'(st_um);
  assign st_t     = PopW'(in_sample_q);
  assign st_tc    = (st_t > st_n) ? st_n : st_t;
  assign st_comp  = !(st_tc < (st_n >> 1));
  assign st_draws = st_comp ? (st_n - st_tc) : st_tc;

  // draw test: pop_left * u < marked_left * 2^FracBits, exact
  logic [WideW-1:0]     u_wide;
  logic [FracBits-1:0]  u_fix;
  logic [ProdW-1:0]     prod, limit;
  logic                 sel;
  logic [CountBits-1:0] found_inc, found_nx;
  logic [PopW-1:0]      draws_dec;

  assign u_wide    = WideW'(in_uniform_q) << ShiftL;
  assign u_fix     = FracBits'(u_wide >> ShiftR);
  assign prod      = ProdW'(pop_q) * ProdW'(u_fix);
  assign limit     = ProdW'(mleft_q) << FracBits;
  assign sel       = (pop_q != '0) && (prod < limit);
  assign found_inc = found_q + CountBits'(1);
  assign found_nx  = sel ? found_inc : found_q;
  assign draws_dec = draws_q - PopW'(1);

  logic             res_valid;
  logic [OUT_W-1:0] res_data;

  always_comb begin
    busy_d    = busy_q;
    comp_d    = comp_q;
    mtotal_d  = mtotal_q;
    mleft_d   = mleft_q;
    pop_d     = pop_q;
    found_d   = found_q;
    draws_d   = draws_q;
    res_valid = 1'b0;
    res_data  = '0;
    if (fire) begin
      if (in_cmd_q == CMD_START) begin
        // a start always drops whatever sample was running
        comp_d   = st_comp;
        mtotal_d = st_m;
        mleft_d  = st_m;
        pop_d    = st_n;
        found_d  = '0;
        draws_d  = st_draws;
        if (st_draws == '0) begin
          busy_d    = 1'b0;
          res_valid = 1'b1;
          res_data  = st_comp ? OUT_W'(st_m) : '0;
        end else begin
          busy_d = 1'b1;
        end
      end else if (busy_q) begin
        found_d = found_nx;
        if (sel && (found_inc == mtotal_q)) begin
          // last marked member found: finish early
          busy_d    = 1'b0;
          res_valid = 1'b1;
          res_data  = comp_q ? '0 : OUT_W'(found_inc);
        end else begin
          if (sel) begin
            mleft_d = mleft_q - CountBits'(1);
          end
          pop_d   = pop_q - PopW'(1);
          draws_d = draws_dec;
          if (draws_dec == '0) begin
            busy_d    = 1'b0;
            res_valid = 1'b1;
            res_data  = comp_q ? OUT_W'(mtotal_q - found_nx) : OUT_W'(found_nx);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      comp_q   <= 1'b0;
      mtotal_q <= '0;
      mleft_q  <= '0;
      pop_q    <= '0;
      found_q  <= '0;
      draws_q  <= '0;
    end else begin
      busy_q   <= busy_d;
      comp_q   <= comp_d;
      mtotal_q <= mtotal_d;
      mleft_q  <= mleft_d;
      pop_q    <= pop_d;
      found_q  <= found_d;
      draws_q  <= draws_d;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data_q);

endmodule

[design/hgss_checker.sv]
// Port-level checks for the hypergeometric sampler top level, bound in below.
// Depends on hgss_pkg for the output tdata width.
module hgss_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [hgss_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import hgss_pkg::*;

  // held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_out_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // input backpressure only when a result is stuck downstream
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  // a fresh result follows an input transfer through the input and result registers
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching input transfer");

endmodule

bind hypergeometric_sequential_sampler_unit hgss_checker u_hgss_checker (.*);

[sim/tb.sv]
// Self-checking testbench for hypergeometric_sequential_sampler_unit.
// Needs hgss_pkg and the unit's RTL. A built-in predictor tracks the sampler state,
// random stalls are applied on both streams, and every result is checked in order.
`timescale 1ns / 1ps

module tb;
  import hgss_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned TARGET_ITEMS   = 1100;

  // One input item, unpacked
  typedef struct packed {
    cmd_e                  cmd;
    logic [MARKED_W-1:0]   marked;
    logic [UNMARKED_W-1:0] unmarked;
    logic [SAMPLE_W-1:0]   sample;
    logic [UNIFORM_W-1:0]  uniform;
  } sample_req_t;

  // Sampler state as seen from outside
  typedef struct packed {
    logic                busy;
    logic                complement;
    logic [OUT_W-1:0]    marked_total;
    logic [OUT_W-1:0]    marked_left;
    logic [OUT_W-1:0]    found;
    logic [SAMPLE_W-1:0] pop_left;
    logic [SAMPLE_W-1:0] draws_left;
  } sampler_state_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  // marked_count, unmarked_count, sample_size, uniform_fraction, zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // command
  logic [0:0]             s_axis_tuser  = CMD_START;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // marked_in_sample
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;

  sample_req_t       pending_items[$];
  logic [OUT_W-1:0]  expected_counts[$];
  sampler_state_t    gen_state;   // shadow used while building the stimulus
  sampler_state_t    model_state; // advanced on accepted transfers
  sample_req_t       driven_item;
  int                fails      = 0;
  int                counted    = 0;
  int unsigned       cycle_cnt  = 0;
  int unsigned       stall_cnt  = 0;

  hypergeometric_sequential_sampler_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // No random idling on either side inside this window
  wire quiet = (cycle_cnt >= 600) && (cycle_cnt < 1300);

  // Next sampler state for one item; returns 1 when the item yields a count.
  // Fraction width is the package default of 32, so u is used as is.
  function automatic bit step_sampler(input sampler_state_t cur, input sample_req_t req,
                                      output sampler_state_t nxt,
                                      output logic [OUT_W-1:0] count);
    logic [SAMPLE_W-1:0] pop;
    logic [SAMPLE_W-1:0] want;
    logic [63:0]         lhs;
    logic [63:0]         rhs;
    nxt   = cur;
    count = '0;
    if (req.cmd == CMD_START) begin
      pop  = {1'b0, req.marked} + {1'b0, req.unmarked};
      want = (req.sample > pop) ? pop : req.sample;
      nxt.marked_total = req.marked;
      nxt.marked_left  = req.marked;
      nxt.pop_left     = pop;
      nxt.found        = '0;
      // at or above half the population, draw the complement instead
      nxt.complement   = !(want < (pop >> 1));
      nxt.draws_left   = nxt.complement ? pop - want : want;
      if (nxt.draws_left == '0) begin
        nxt.busy = 1'b0;
        count    = nxt.complement ? nxt.marked_total : '0;
        return 1'b1;
      end
      nxt.busy = 1'b1;
      return 1'b0;
    end
    if (!cur.busy) return 1'b0;  // stray draw
    // exact test: pop_left * u / 2^32 < marked_left
    lhs = 64'(cur.pop_left) * 64'(req.uniform);
    rhs = 64'(cur.marked_left) << FRAC_BITS_DEF;
    if ((cur.pop_left != '0) && (lhs < rhs)) begin
      nxt.found = cur.found + 1'b1;
      if (nxt.found == cur.marked_total) begin
        // every marked member found: finish early
        nxt.busy = 1'b0;
        count    = cur.complement ? '0 : nxt.found;
        return 1'b1;
      end
      nxt.marked_left = cur.marked_left - 1'b1;
    end
    nxt.pop_left   = cur.pop_left - 1'b1;
    nxt.draws_left = cur.draws_left - 1'b1;
    if (nxt.draws_left == '0) begin
      nxt.busy = 1'b0;
      count    = cur.complement ? cur.marked_total - nxt.found : nxt.found;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Unused fields carry random garbage
  function automatic sample_req_t mk_start(input int m, input int um, input int s);
    sample_req_t r;
    r.cmd      = CMD_START;
    r.marked   = MARKED_W'(m);
    r.unmarked = UNMARKED_W'(um);
    r.sample   = SAMPLE_W'(s);
    r.uniform  = $urandom;
    return r;
  endfunction

  function automatic sample_req_t mk_draw(input logic [UNIFORM_W-1:0] u);
    sample_req_t r;
    r.cmd      = CMD_DRAW;
    r.marked   = MARKED_W'($urandom);
    r.unmarked = UNMARKED_W'($urandom);
    r.sample   = SAMPLE_W'($urandom);
    r.uniform  = u;
    return r;
  endfunction

  function automatic logic [UNIFORM_W-1:0] rand_uniform();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  // Queue an item; items the block would ignore are not counted
  task automatic queue_item(input sample_req_t req);
    sampler_state_t   nxt;
    logic [OUT_W-1:0] unused_count;
    if (req.cmd == CMD_START || gen_state.busy) counted++;
    void'(step_sampler(gen_state, req, nxt, unused_count));
    gen_state = nxt;
    pending_items.push_back(req);
  endtask

  // Driver: predicts on each accepted transfer, then presents the next item
  always @(posedge clk_i) begin : drive_b
    logic             fire;
    logic             has_count;
    logic [OUT_W-1:0] count;
    sampler_state_t   nxt;
    sample_req_t      req;
    logic [IN_TDATA_W-1:0] word;
    if (rst_ni) begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        has_count   = step_sampler(model_state, driven_item, nxt, count);
        model_state = nxt;
        if (has_count) expected_counts.push_back(count);
      end
      if (!s_axis_tvalid || fire) begin
        if (pending_items.size() != 0 && (quiet || $urandom_range(0, 99) >= 25)) begin
          req  = pending_items.pop_front();
          word = '0;
          word[MARKED_LSB   +: MARKED_W]   = req.marked;
          word[UNMARKED_LSB +: UNMARKED_W] = req.unmarked;
          word[SAMPLE_LSB   +: SAMPLE_W]   = req.sample;
          word[UNIFORM_LSB  +: UNIFORM_W]  = req.uniform;
          driven_item   = req;
          s_axis_tdata  <= word;
          s_axis_tuser  <= req.cmd;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: in-order compare against the oldest expected count
  always @(posedge clk_i) begin : check_b
    logic [OUT_W-1:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_counts.size() == 0) begin
          $error("marked_in_sample: expected none, actual %0d", m_axis_tdata[OUT_W-1:0]);
          fails++;
        end else begin
          want = expected_counts.pop_front();
          if (m_axis_tdata[OUT_W-1:0] !== want) begin
            $error("marked_in_sample: expected %0d, actual %0d", want,
                   m_axis_tdata[OUT_W-1:0]);
            fails++;
          end
        end
      end
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 25);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else if (rst_ni) begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WATCHDOG_LIMIT) begin
        $display("hypergeometric_sequential_sampler_unit verification failed");
        $finish;
      end
    end
  end

  initial begin : stim_b
    int unsigned pick;
    int          m;
    int          um;
    int          pop;
    int          s;
    int          cut;
    int          taken;
    gen_state   = '0;
    model_state = '0;

    // Directed part
    queue_item(mk_draw('1));                  // draw while idle: ignored
    queue_item(mk_start(0, 0, 0));            // empty population, zero draws
    queue_item(mk_start(65535, 65535, 131070)); // full population, complement, zero draws
    queue_item(mk_start(65535, 0, 0));        // direct, zero draws
    queue_item(mk_start(3, 5, 3));            // direct, three draws
    queue_item(mk_draw('0));
    queue_item(mk_draw('1));
    queue_item(mk_draw('0));
    queue_item(mk_start(2, 10, 5));           // all marked found early
    queue_item(mk_draw('0));
    queue_item(mk_draw('0));
    queue_item(mk_start(1, 5, 5));            // complement, last marked found
    queue_item(mk_draw('0));
    queue_item(mk_start(0, 6, 2));            // no marked members
    queue_item(mk_draw('0));
    queue_item(mk_draw('0));
    queue_item(mk_start(5, 5, 4));            // dropped by the next start
    queue_item(mk_draw('1));
    queue_item(mk_start(1, 1, 5));            // clamped sample size
    queue_item(mk_start(1, 3, 1));            // product equals bound: no pick
    queue_item(mk_draw(32'h4000_0000));
    queue_item(mk_start(1, 3, 1));            // just below bound: pick
    queue_item(mk_draw(32'h3FFF_FFFF));
    queue_item(mk_start(4, 4, 6));            // complement with draws
    queue_item(mk_draw('0));
    queue_item(mk_draw('0));

    // Random part: mostly complete samples with random draws
    while (counted < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        m  = $urandom_range(0, 12);
        um = $urandom_range(0, 12);
        s  = $urandom_range(0, m + um + 2);
      end else if (pick < 82) begin
        m   = $urandom_range(0, 65535);
        um  = $urandom_range(0, 65535);
        pop = m + um;
        case ($urandom_range(0, 2))
          0:       s = $urandom_range(0, 6);
          1:       s = (pop > 6) ? pop - $urandom_range(0, 6) : 0;
          default: s = $urandom_range(pop, 131070);
        endcase
      end else if (pick < 87) begin
        m  = $urandom_range(0, 200);
        um = $urandom_range(0, 200);
        s  = $urandom_range(0, m + um);
      end else begin
        // noise: stray draws and starts that get dropped
        if (pick < 94) queue_item(mk_draw($urandom));
        else queue_item(mk_start($urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 131070)));
        continue;
      end
      queue_item(mk_start(m, um, s));
      cut   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : -1;
      taken = 0;
      while (gen_state.busy && taken != cut) begin
        queue_item(mk_draw(rand_uniform()));
        taken++;
      end
      if ($urandom_range(0, 7) == 0) queue_item(mk_draw($urandom));
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fails == 0) begin
      $display("hypergeometric_sequential_sampler_unit verification clean");
    end else begin
      $display("hypergeometric_sequential_sampler_unit verification failed");
    end
    $finish;
  end

endmodule

[hypergeometric_sequential_sampler_unit.f]
design/hgss_pkg.sv
design/hypergeometric_sequential_sampler_unit.sv
design/hgss_checker.sv
sim/tb.sv
